FILE: hdl/bdq_pkg.sv
package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int CAP_W   = 5;
    localparam int FILL_W  = 5;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_NONE       = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
    } t_cfg;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic [FILL_W-1:0]        fill_count;
        logic                     is_empty;
        logic                     is_full;
    } t_result;

    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] c;
        c = CMP_W'(cap);
        if (c > CMP_W'(DEPTH)) begin
            return CNT_W'(DEPTH);
        end
        return CNT_W'(cap);
    endfunction

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0] s;
        s = SUM_W'(ptr) + SUM_W'(cnt);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return PTR_W'(s);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return ptr + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] ptr);
        if (ptr == '0) begin
            return PTR_W'(DEPTH - 1);
        end
        return ptr - PTR_W'(1);
    endfunction

endpackage

FILE: hdl/bdq_ifs.sv
interface bdq_in_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] data_value;

    modport source (output valid, output cmd, output data_value, input ready);
    modport sink   (input valid, input cmd, input data_value, output ready);
endinterface

interface bdq_out_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output fill_count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input fill_count, input is_empty, input is_full, output ready);
endinterface

FILE: hdl/bdq_ram.sv
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end
endmodule

FILE: hdl/bdq_apb_regs.sv
module bdq_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdq_pkg::APB_AW-1:0]   paddr,
    input  logic [bdq_pkg::APB_DW-1:0]   pwdata,
    output logic [bdq_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output bdq_pkg::t_cfg                o_cfg
);
    import bdq_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             wr_en;
    logic             sel_cap;

    assign pready  = 1'b1;
    assign sel_cap = (paddr[APB_AW-1:2] == REG_CAPACITY);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (wr_en && sel_cap) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_cap) begin
            prdata = APB_DW'(r_capacity);
        end
    end

    assign o_cfg.capacity = r_capacity;
endmodule

FILE: hdl/bdq_core.sv
module bdq_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bdq_pkg::t_cfg i_cfg,
    bdq_in_if.sink        i_in,
    bdq_out_if.source     o_out
);
    import bdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_ok, n_ok;
    logic              r_out_valid;
    t_result           r_out;

    logic              accept;
    logic              room;
    logic              nonempty;
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [PTR_W-1:0]  rear_addr;
    logic [DATA_W-1:0] rd_front;
    logic [DATA_W-1:0] rd_rear;
    logic [CNT_W-1:0]  cap;
    logic              slot_free;
    t_result           result;

    assign cap       = eff_cap(i_cfg.capacity);
    assign i_in.ready = (r_state == S_IDLE);
    assign accept    = i_in.valid && i_in.ready;
    assign room      = r_count < cap;
    assign nonempty  = r_count != '0;
    assign slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_ok    = 1'b0;
        we      = 1'b0;
        waddr   = wrap_add(r_front, r_count);
        case (t_cmd'(i_in.cmd))
            CMD_PUSH_FRONT: begin
                if (room) begin
                    n_front = ptr_dec(r_front);
                    waddr   = ptr_dec(r_front);
                    we      = accept;
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            CMD_PUSH_REAR: begin
                if (room) begin
                    we      = accept;
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (nonempty) begin
                    n_front = ptr_inc(r_front);
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            CMD_POP_REAR: begin
                if (nonempty) begin
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            CMD_NONE: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    assign rear_addr = wrap_add(r_front, nonempty ? r_count - CNT_W'(1) : '0);

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_in.data_value),
        .i_re      (r_state == S_READ),
        .i_raddr_a (r_front),
        .i_raddr_b (rear_addr),
        .o_rdata_a (rd_front),
        .o_rdata_b (rd_rear)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        result.ok          = r_ok;
        result.front_value = nonempty ? rd_front : EMPTY_WORD;
        result.rear_value  = nonempty ? rd_rear : EMPTY_WORD;
        result.fill_count  = FILL_W'(r_count);
        result.is_empty    = !nonempty;
        result.is_full     = r_count >= cap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_front <= n_front;
                r_count <= n_count;
                r_ok    <= n_ok;
            end
            if (r_state == S_LOAD && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && slot_free) begin
            r_out <= result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.ok          = r_out.ok;
    assign o_out.front_value = r_out.front_value;
    assign o_out.rear_value  = r_out.rear_value;
    assign o_out.fill_count  = r_out.fill_count;
    assign o_out.is_empty    = r_out.is_empty;
    assign o_out.is_full     = r_out.is_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Fill count exceeds the buffer depth.");

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_READ))
        else $error("An accepted transfer did not start a memory read.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_count == $past(r_count)
            || r_count == $past(r_count) + CNT_W'(1)
            || r_count == $past(r_count) - CNT_W'(1)))
        else $error("Fill count moved by more than one in a single transfer.");

    a_load_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_LOAD))
        else $error("A result appeared before its memory read completed.");
endmodule

FILE: hdl/bounded_deque_unit.sv
// Channel   Direction  Contents
// i_in      sink       cmd, data_value
// o_out     source     ok, front_value, rear_value, fill_count, is_empty, is_full
// APB       slave      capacity at byte address 0
//
// Each command passes from transfer to result through the update and
// memory write, the memory read of the front and rear words, and the output load.
// The slot memory read is registered, so the read has a step of its own.
// Reset clears the pointers and the count; capacity returns to 16.
// A stalled result holds the sequencer in its last step, and a new
// transfer is taken as soon as the result has moved to the output register.
module bounded_deque_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bdq_in_if.sink                     i_in,
    bdq_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bdq_pkg::APB_AW-1:0] paddr,
    input  logic [bdq_pkg::APB_DW-1:0] pwdata,
    output logic [bdq_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import bdq_pkg::*;

    t_cfg cfg;

    bdq_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bdq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

FILE: tb/bdq_checker.sv
module bdq_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bdq_in_if                          in_mon,
    bdq_out_if                         out_mon,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [bdq_pkg::APB_AW-1:0] i_paddr,
    input  logic [bdq_pkg::APB_DW-1:0] i_pwdata,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_result_count,
    output int                         o_refused_count
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] slot_word [DEPTH];
    logic [PTR_W-1:0]  front_ptr;
    logic [CNT_W-1:0]  held;
    logic [CAP_W-1:0]  cap_reg;
    t_result           expected_q [$];

    function automatic t_result apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic [DATA_W-1:0] word);
        t_result r;
        int      limit;
        bit      room;
        limit = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        room  = int'(held) < limit;
        r.ok  = 1'b0;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (room) begin
                    front_ptr = PTR_W'((int'(front_ptr) + DEPTH - 1) % DEPTH);
                    slot_word[front_ptr] = word;
                    held = held + 1'b1;
                    r.ok = 1'b1;
                end
            end
            CMD_PUSH_REAR: begin
                if (room) begin
                    slot_word[PTR_W'((int'(front_ptr) + int'(held)) % DEPTH)] = word;
                    held = held + 1'b1;
                    r.ok = 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (held != 0) begin
                    front_ptr = PTR_W'((int'(front_ptr) + 1) % DEPTH);
                    held = held - 1'b1;
                    r.ok = 1'b1;
                end
            end
            CMD_POP_REAR: begin
                if (held != 0) begin
                    held = held - 1'b1;
                    r.ok = 1'b1;
                end
            end
            CMD_NONE: begin
                r.ok = 1'b1;
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        if (held != 0) begin
            r.front_value = slot_word[front_ptr];
            r.rear_value  = slot_word[PTR_W'((int'(front_ptr) + int'(held) - 1) % DEPTH)];
        end else begin
            r.front_value = EMPTY_WORD;
            r.rear_value  = EMPTY_WORD;
        end
        r.fill_count = FILL_W'(held);
        r.is_empty   = (held == 0);
        r.is_full    = (int'(held) >= limit);
        return r;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            front_ptr = '0;
            held = '0;
            cap_reg = CAP_RESET;
            expected_q.delete();
            o_fail_count = 0;
            o_pending = 0;
            o_result_count = 0;
            o_refused_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[APB_AW-1:2] == REG_CAPACITY) begin
                cap_reg = i_pwdata[CAP_W-1:0];
            end
            if (in_mon.valid && in_mon.ready) begin
                want = apply_command(in_mon.cmd, in_mon.data_value);
                expected_q.push_back(want);
                if (!want.ok) begin
                    o_refused_count++;
                end
            end
            if (out_mon.valid && out_mon.ready) begin
                o_result_count++;
                if (expected_q.size() == 0) begin
                    $error("Result transfer arrived with no command outstanding.");
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("ok", want.ok, out_mon.ok);
                    compare_field("front_value", $signed(want.front_value),
                                  $signed(out_mon.front_value));
                    compare_field("rear_value", $signed(want.rear_value),
                                  $signed(out_mon.rear_value));
                    compare_field("fill_count", want.fill_count, out_mon.fill_count);
                    compare_field("is_empty", want.is_empty, out_mon.is_empty);
                    compare_field("is_full", want.is_full, out_mon.is_full);
                end
            end
            o_pending = expected_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import bdq_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int PHASE_ITEMS   = 84;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int PAUSE_CYCLES  = 4;

    localparam logic [APB_AW-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE    = {~REG_CAPACITY, 2'b00};
    localparam logic [CMD_W-1:0]  CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_RSVD_MID   = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_RSVD_LAST  = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    int fail_count;
    int pending_results;
    int result_count;
    int refused_count;
    int sent_count = 0;
    int cfg_writes = 0;
    int stall_cycles = 0;
    int hold_requests = 0;
    int holds_done = 0;
    bit quiet = 1'b0;

    bdq_in_if  in_ch ();
    bdq_out_if out_ch ();

    bounded_deque_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bdq_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results),
        .o_result_count  (result_count),
        .o_refused_count (refused_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("bounded_deque_unit verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done < hold_requests) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
                repeat ($urandom_range(1, 20) - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] word);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.cmd = cmd;
        in_ch.data_value = word;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (PAUSE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        wait_drained();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        cfg_writes++;
    endtask

    task automatic run_random_phase(input logic [APB_AW-1:0] addr,
                                    input logic [APB_DW-1:0] value,
                                    input bit last, input bit squeeze);
        int pick;
        int bias;
        logic [CMD_W-1:0] cmd;
        logic [DATA_W-1:0] word;
        bias = 50;
        apb_write(addr, value);
        quiet = last;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 16 == 0) begin
                case ($urandom_range(0, 2))
                    0: bias = 85;
                    1: bias = 50;
                    default: bias = 15;
                endcase
            end
            if (squeeze && n < 48) begin
                bias = 85;
            end
            if (squeeze && n == 20) begin
                hold_requests++;
            end
            pick = $urandom_range(0, 99);
            if (pick < bias) begin
                cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
            end else if (pick < 94) begin
                cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
            end else if (pick < 97) begin
                cmd = CMD_NONE;
            end else begin
                cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
            end
            case ($urandom_range(0, 9))
                0: word = 32'h8000_0000;
                1: word = 32'h7FFF_FFFF;
                2: word = EMPTY_WORD;
                default: word = $urandom;
            endcase
            send_cmd(cmd, word);
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_NONE;
        in_ch.data_value = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_NONE, 32'h1234_5678);
        send_cmd(CMD_RSVD_FIRST, 32'hDEAD_BEEF);
        send_cmd(CMD_RSVD_MID, 32'h0);
        send_cmd(CMD_RSVD_LAST, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
        send_cmd(CMD_PUSH_REAR, 32'h7FFF_FFFF);
        send_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH_REAR, 32'h0);
        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_PUSH_REAR, 32'hAAAA_AAAA);
        send_cmd(CMD_PUSH_FRONT, 32'h5555_5555);
        apb_write(ADDR_CAPACITY, 32'd2);
        send_cmd(CMD_PUSH_REAR, 32'h1);
        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_PUSH_FRONT, 32'h1234_5678);
        apb_write(ADDR_CAPACITY, 32'd0);
        send_cmd(CMD_PUSH_REAR, 32'h2);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_PUSH_FRONT, 32'h3);

        run_random_phase(ADDR_CAPACITY, 32'd16, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'd1, 1'b0, 1'b0);
        run_random_phase(ADDR_SPARE, 32'd3, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'd31, 1'b0, 1'b1);
        run_random_phase(ADDR_CAPACITY, 32'd5, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'd0, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'd17, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'd8, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'hFFFF_FFE3, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'd16, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'd12, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'd2, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'd31, 1'b0, 1'b0);
        run_random_phase(ADDR_CAPACITY, 32'd16, 1'b1, 1'b0);

        in_ch.valid = 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Summary: %0d commands sent, %0d results checked, %0d refused, %0d config writes.",
                 sent_count, result_count, refused_count, cfg_writes);
        $display("Capacities ran from zero through full depth to above depth, with output stalls.");
        if (fail_count == 0 && pending_results == 0) begin
            $display("bounded_deque_unit verification clean");
        end else begin
            $display("bounded_deque_unit verification failed");
        end
        $finish;
    end

endmodule
